>>> rtl/core/bcc_pkg.sv
// bcc_pkg: shared types and constants for the button click classifier.
// No dependencies; imported by bcc_lane and button_click_classifier.
package bcc_pkg;

  localparam int NUM_BUTTONS   = 2;
  localparam int TICK_W        = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd50;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd500;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 8'd1;

  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_SINGLE = 2'd1,
    EVT_DOUBLE = 2'd2
  } evt_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] double_click_ticks;
  } cfg_t;

endpackage

>>> rtl/core/button_click_classifier.sv
// button_click_classifier: top level, tick counter, config registers, lanes, output stage.
// Depends on bcc_pkg and bcc_lane.
//
// Usage:
//  - Input channel (in_valid/in_ready): one transaction per millisecond tick,
//    carrying the press-edge bit of each button (in_first_edge, in_second_edge).
//  - Result channel (out_valid/out_ready): exactly one transaction per tick,
//    an event code per button: none, single click or double click.
//  - Config channel (cfg_valid/cfg_ready): index 0 debounce_ticks, index 1
//    double_click_ticks, low 16 bits of cfg_wdata used; other indexes ignored.
//    cfg_ready is always high; write only while the block is idle.
//  - Result timing: registered, it appears in the cycle after the tick is accepted.
//  - Throughput: one tick per cycle while results are taken. Each button lane
//    judges its edge with two combinational 32-bit subtract-and-compare paths,
//    and the result register refills in the same cycle it is drained.
//  - Stall: a held result keeps in_ready low until out_ready takes it, so no
//    tick is lost or reordered.
//  - Reset: tick counter, stamps and pending flags clear to zero, config
//    returns to 50 / 500, output register empties. Edges in ticks 0 through
//    debounce_ticks are rejected as if an edge had been accepted at tick 0.
module button_click_classifier
  import bcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // tick input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_first_edge,
  input  logic                 in_second_edge,
  // event output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_first_event,
  output logic [1:0]           out_second_event,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [TICK_W-1:0] tick_r;
  cfg_t              cfg_r;
  logic              out_valid_r;
  evt_t              evt_r [NUM_BUTTONS];

  logic              step;
  logic [NUM_BUTTONS-1:0] edges;
  evt_t              lane_evt [NUM_BUTTONS];

  // output register frees up in the same cycle it is drained
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign edges = {in_second_edge, in_first_edge};

  // one lane per button, all judged against the same tick
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    bcc_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (step),
      .edge_in (edges[b]),
      .now     (tick_r),
      .cfg     (cfg_r),
      .evt     (lane_evt[b])
    );
  end

  // tick counter wraps mod 2^32
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (step) begin
      tick_r <= tick_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= DEBOUNCE_RESET;
      cfg_r.double_click_ticks <= DOUBLE_CLICK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:     cfg_r.debounce_ticks     <= cfg_wdata;
        REG_DOUBLE_CLICK: cfg_r.double_click_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // merge stage: lane events captured together as one result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        evt_r[b] <= lane_evt[b];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_event  = evt_r[0];
  assign out_second_event = evt_r[1];

  // every accepted tick produces a result next cycle
  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted tick produced no result");

  // tick counter advances exactly once per accepted tick
  a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (tick_r == $past(tick_r) + 1'b1))
    else $error("tick counter did not advance");

  a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(tick_r))
    else $error("tick counter moved without a tick");

  // no input taken while a stalled result is still held
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !step)
    else $error("tick accepted over a held result");

endmodule

>>> rtl/core/bcc_lane.sv
// bcc_lane: debounce and single/double click judgment for one button.
// Depends on bcc_pkg (cfg_t, evt_t, widths).
module bcc_lane
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,     // tick transaction accepted this cycle
  input  logic              edge_in,
  input  logic [TICK_W-1:0] now,
  input  cfg_t              cfg,
  output evt_t              evt
);

  logic [TICK_W-1:0] accepted_stamp_r, accepted_stamp_nxt;
  logic [TICK_W-1:0] pending_stamp_r,  pending_stamp_nxt;
  logic              pending_valid_r,  pending_valid_nxt;

  logic [TICK_W-1:0] acc_age;
  logic [TICK_W-1:0] pend_age;
  logic              edge_ok;
  logic              is_double;
  logic              expired;

  assign acc_age  = now - accepted_stamp_r;
  assign pend_age = now - pending_stamp_r;

  assign edge_ok   = edge_in && (acc_age > {{(TICK_W-CFG_W){1'b0}}, cfg.debounce_ticks});
  assign is_double = edge_ok && pending_valid_r &&
                     (pend_age < {{(TICK_W-CFG_W){1'b0}}, cfg.double_click_ticks});
  // a freshly stamped press has age zero and cannot expire in the same tick
  assign expired   = !edge_ok && pending_valid_r &&
                     (pend_age > {{(TICK_W-CFG_W){1'b0}}, cfg.double_click_ticks});

  always_comb begin
    accepted_stamp_nxt = accepted_stamp_r;
    pending_stamp_nxt  = pending_stamp_r;
    pending_valid_nxt  = pending_valid_r;
    evt                = EVT_NONE;
    if (edge_ok) begin
      accepted_stamp_nxt = now;
      if (is_double) begin
        evt               = EVT_DOUBLE;
        pending_valid_nxt = 1'b0;
      end else begin
        pending_stamp_nxt = now;
        pending_valid_nxt = 1'b1;
      end
    end else if (expired) begin
      evt               = EVT_SINGLE;
      pending_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_stamp_r <= '0;
      pending_stamp_r  <= '0;
      pending_valid_r  <= 1'b0;
    end else if (step) begin
      accepted_stamp_r <= accepted_stamp_nxt;
      pending_stamp_r  <= pending_stamp_nxt;
      pending_valid_r  <= pending_valid_nxt;
    end
  end

  // a double click needs a pending press to pair with
  a_double_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (evt == EVT_DOUBLE) |-> pending_valid_r)
    else $error("double click without pending press");

  // a step that reports any click leaves nothing pending
  a_click_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (step && evt != EVT_NONE) |=> !pending_valid_r)
    else $error("pending press survived a reported click");

  // a single click only comes from expiry, never alongside an accepted edge
  a_single_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (evt == EVT_SINGLE) |-> !edge_ok)
    else $error("single click reported with an accepted edge");

endmodule
